// ===== hdl/assert_macros.svh =====
// assertion helpers used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on a clock, muted while reset is high
`define DWVS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dwvs assertion failed");

// implication check on a clock, muted while reset is high
`define DWVS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwvs implication failed");

`endif

// ===== hdl/dwvs_pkg.sv =====
// ----------------------------------------------------------------------------
// dwvs_pkg
// types, codes and ring index helpers for the deque with value search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwvs_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_SEARCH     = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_code_t;

  typedef struct packed {
    req_code_t                 req_type;
    logic signed [VAL_W-1:0]   value;
  } in_t;

  typedef struct packed {
    status_code_t              status;
    logic                      found;
    logic [POS_W-1:0]          position;
    logic signed [VAL_W-1:0]   front_value;
    logic signed [VAL_W-1:0]   back_value;
    logic [POS_W-1:0]          entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic         load_req;
    logic         push_back;
    logic         push_front;
    logic         pop;
    logic         srch_start;
    logic         srch_step;
    logic         front_from_rd;
    logic         status_load;
    status_code_t status_code;
    logic         out_load;
  } dwvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_code_t req_type;
    logic      full;
    logic      empty;
    logic      srch_hit;
    logic      srch_last;
    logic      out_free;
  } dwvs_status_t;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // (base - 1) mod DEPTH
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dwvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwvs_ctrl
// request sequencer: accepts a beat, runs the operation, hands off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwvs_ctrl import dwvs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  dwvs_status_t stat,
  output dwvs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = rst | (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.req_type)
          REQ_PUSH_BACK: begin
            if (stat.full) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.push_back = 1'b1;
            end
            state_next = S_DONE;
          end
          REQ_PUSH_FRONT: begin
            if (stat.full) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.push_front = 1'b1;
            end
            state_next = S_DONE;
          end
          REQ_POP_FRONT: begin
            if (stat.empty) begin
              cmd.status_load = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_POPRD;
            end
          end
          REQ_SEARCH: begin
            if (stat.empty) begin
              state_next = S_DONE;
            end else begin
              cmd.srch_start = 1'b1;
              state_next     = S_SEARCH;
            end
          end
        endcase
      end
      S_POPRD: begin
        cmd.front_from_rd = 1'b1;
        state_next        = S_DONE;
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_hit || stat.srch_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dwvs_datapath.sv =====
// ----------------------------------------------------------------------------
// dwvs_datapath
// ring storage, front/back tracking, search compare and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dwvs_datapath import dwvs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  in_t          req,
  input  dwvs_cmd_t    cmd,
  input  logic         rsp_stall,
  output out_t         rsp,
  output logic         rsp_valid,
  output dwvs_status_t stat
);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] front_index;
  logic [CNT_W-1:0] count;
  req_code_t        req_type;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] front_val;
  logic [VAL_W-1:0] back_val;
  status_code_t     status;
  logic             found;
  logic [POS_W-1:0] position;
  logic [IDX_W-1:0] soff;
  logic [VAL_W-1:0] rdata;

  logic             empty;
  logic             full;
  logic [IDX_W-1:0] back_slot;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] soff_next;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             hit;
  logic             last;

  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign back_slot = ring_add(front_index, IDX_W'(count));
  assign front_dec = ring_dec(front_index);
  assign front_inc = ring_add(front_index, IDX_W'(1));
  assign soff_next = soff + IDX_W'(1);
  assign hit       = (rdata == value);
  assign last      = (soff == IDX_W'(count - CNT_W'(1)));

  assign rd_en   = cmd.pop | cmd.srch_start | cmd.srch_step;
  assign wr_en   = cmd.push_back | cmd.push_front;
  assign wr_addr = cmd.push_front ? front_dec : back_slot;

  always_comb begin
    priority if (cmd.pop) begin
      rd_addr = front_inc;
    end else if (cmd.srch_start) begin
      rd_addr = front_index;
    end else begin
      rd_addr = ring_add(front_index, soff_next);
    end
  end

  assign stat.req_type  = req_type;
  assign stat.full      = full;
  assign stat.empty     = empty;
  assign stat.srch_hit  = hit;
  assign stat.srch_last = last;
  assign stat.out_free  = ~rsp_valid | ~rsp_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      count       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.push_back) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.push_front) begin
        front_index <= front_dec;
        count       <= count + CNT_W'(1);
      end
      if (cmd.pop) begin
        front_index <= front_inc;
        count       <= count - CNT_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type <= req.req_type;
      value    <= req.value;
      status   <= ST_OK;
      found    <= 1'b0;
      position <= '0;
    end
    if (cmd.status_load) begin
      status <= cmd.status_code;
    end
    if (cmd.push_back) begin
      back_val <= value;
      if (empty) begin
        front_val <= value;
      end
    end
    if (cmd.push_front) begin
      front_val <= value;
      if (empty) begin
        back_val <= value;
      end
    end
    if (cmd.front_from_rd) begin
      front_val <= rdata;
    end
    if (cmd.srch_start) begin
      soff <= '0;
    end
    if (cmd.srch_step) begin
      if (hit) begin
        found    <= 1'b1;
        position <= POS_W'(soff) + POS_W'(1);
      end else begin
        soff <= soff_next;
      end
    end
    if (cmd.out_load) begin
      rsp.status      <= status;
      rsp.found       <= found;
      rsp.position    <= position;
      rsp.front_value <= empty ? '0 : front_val;
      rsp.back_value  <= empty ? '0 : back_val;
      rsp.entry_count <= POS_W'(count);
    end
  end

  `DWVS_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `DWVS_ASSERT(a_front_bound, clk, rst, front_index <= IDX_W'(DEPTH - 1))
  `DWVS_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !rsp_valid || !rsp_stall)
  `DWVS_ASSERT_IMP(a_search_nonempty, clk, rst, cmd.srch_step, count != '0)

endmodule

`default_nettype wire

// ===== hdl/deque_with_value_search_unit.sv =====
// sequence: push and failed requests run execute then result handoff, pop adds a front read,
//   search adds a walk over k, the number of entries compared (one storage read per cycle)
// throughput: one request at a time; the next beat is taken once the result
//   enters the output register, even while that result still waits downstream
// reset: clears entry count, front index and result valid; storage is not cleared
// ----------------------------------------------------------------------------
// deque_with_value_search_unit
// bounded double-ended queue on a ring buffer with a linear search from front
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deque_with_value_search_unit import dwvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_stall,
  input  in_t  req,
  // result channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp
);

  // command and status bundles between sequencer and datapath
  dwvs_cmd_t    cmd;
  dwvs_status_t stat;

  // sequencer: idle -> execute -> (pop read | search walk) -> result handoff
  dwvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: ring storage, front/back values, search compare, result register
  dwvs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== tb/deque_search_checker.sv =====
// ----------------------------------------------------------------------------
// deque_search_checker
// keeps a shadow copy of the ring, works out the result of every accepted
// request beat and compares each result beat field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_search_checker import dwvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  in_t  req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  out_t rsp,
  output int   fail_count,
  output int   pending
);

  // shadow of the deque contents, front at shadow_head
  logic signed [VAL_W-1:0] shadow_vals [DEPTH];
  int unsigned             shadow_head;
  int unsigned             shadow_fill;

  out_t awaited_results [$];
  int   mismatches;

  // applies one request to the shadow and returns the result it must produce
  function automatic out_t next_deque_result(input in_t item);
    out_t view;
    int   i;
    view = '0;
    view.status = ST_OK;
    case (item.req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          view.status = ST_FULL;
        end else if (item.req_type == REQ_PUSH_BACK) begin
          shadow_vals[(shadow_head + shadow_fill) % DEPTH] = item.value;
          shadow_fill++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_vals[shadow_head] = item.value;
          shadow_fill++;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_fill == 0) begin
          view.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      REQ_SEARCH: begin
        for (i = 0; i < shadow_fill; i++) begin
          if (!view.found && shadow_vals[(shadow_head + i) % DEPTH] == item.value) begin
            view.found    = 1'b1;
            view.position = POS_W'(i + 1);
          end
        end
      end
      default: ;
    endcase
    if (shadow_fill != 0) begin
      view.front_value = shadow_vals[shadow_head];
      view.back_value  = shadow_vals[(shadow_head + shadow_fill - 1) % DEPTH];
    end
    view.entry_count = POS_W'(shadow_fill);
    return view;
  endfunction

  task automatic check_field(input string field, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s mismatch: expected 0x%08h, got 0x%08h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      shadow_head = 0;
      shadow_fill = 0;
      awaited_results.delete();
    end else begin
      // result side first: a beat leaving now belongs to an older request
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result beat with nothing awaited: %p", $time, rsp);
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("status",      VAL_W'(want.status),      VAL_W'(rsp.status));
          check_field("found",       VAL_W'(want.found),       VAL_W'(rsp.found));
          check_field("position",    VAL_W'(want.position),    VAL_W'(rsp.position));
          check_field("front_value", want.front_value,         rsp.front_value);
          check_field("back_value",  want.back_value,          rsp.back_value);
          check_field("entry_count", VAL_W'(want.entry_count), VAL_W'(rsp.entry_count));
        end
      end
      if (req_valid && !req_stall) begin
        awaited_results.push_back(next_deque_result(req));
      end
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
  end

endmodule

// ===== tb/deque_with_value_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// deque_with_value_search_unit_tb
// drives request beats into the deque: a directed opening through the empty,
// single-entry and full corners, then random traffic in fill, drain, mixed
// and search-heavy stretches; the checker beside the block scores results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_with_value_search_unit_tb;
  import dwvs_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1850;
  // no beat on either channel for this long means the block is stuck
  localparam int IDLE_LIMIT   = 2000;
  // longest search plus output register, with margin
  localparam int DRAIN_CYCLES = 32;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // shape of a stretch of random traffic
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED,
    MIX_SEARCH_HEAVY
  } traffic_mix_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  int fail_count;
  int pending;

  // sender burst state
  int burst_left = 0;
  int gap_cycles = 0;

  // values that show up repeatedly, so searches hit and duplicates occur
  logic signed [VAL_W-1:0] value_pool [8];
  // last pushed values, searched for often
  logic signed [VAL_W-1:0] recent_pushes [16];
  int                      recent_wr = 0;

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;

  int idle_run;

  always #4 clk = ~clk;

  deque_with_value_search_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deque_search_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: switches between no stall, light, heavy and periodic stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 0);
      default: rsp_stall <= ((stall_left % 8) < 5);
    endcase
  end

  function automatic in_t make_req(input req_code_t code, input logic [VAL_W-1:0] v);
    in_t item;
    item.req_type = code;
    item.value    = v;
    return item;
  endfunction

  // one request beat; idle gaps fall between bursts of random length
  task automatic send_beat(input in_t item);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_cycles > 0) begin
        req_valid <= 1'b0;
        repeat (gap_cycles) @(posedge clk);
      end
    end
    burst_left--;
    req       <= item;
    req_valid <= 1'b1;
    // payload holds until the beat is taken
    do @(posedge clk); while (req_stall);
    if (item.req_type == REQ_PUSH_BACK || item.req_type == REQ_PUSH_FRONT) begin
      recent_pushes[recent_wr] = item.value;
      recent_wr = (recent_wr + 1) % 16;
    end
  endtask

  function automatic logic [VAL_W-1:0] push_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return value_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] search_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      return recent_pushes[$urandom_range(0, 15)];
    end else if (roll < 8) begin
      return value_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  // request mix per stretch: fill runs into full, drain runs into empty
  function automatic in_t random_request(input traffic_mix_t mix);
    int push_pct;
    int pop_pct;
    int roll;
    case (mix)
      MIX_FILL:     begin push_pct = 70; pop_pct = 10; end
      MIX_DRAIN:    begin push_pct = 10; pop_pct = 70; end
      MIX_BALANCED: begin push_pct = 35; pop_pct = 35; end
      default:      begin push_pct = 20; pop_pct = 20; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      return make_req(($urandom_range(0, 1) == 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                      push_value());
    end else if (roll < push_pct + pop_pct) begin
      // value is a don't-care on pop, keep it random
      return make_req(REQ_POP_FRONT, $urandom);
    end
    return make_req(REQ_SEARCH, search_value());
  endfunction

  // watchdog on beats moving on either channel
  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    traffic_mix_t mix;
    int           mix_left;
    int           k;

    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (k = 4; k < 8; k++) begin
      value_pool[k] = $urandom;
    end
    for (k = 0; k < 16; k++) begin
      recent_pushes[k] = value_pool[k % 8];
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed opening ---
    // empty corners: search and pop with nothing stored
    send_beat(make_req(REQ_SEARCH, '0));
    send_beat(make_req(REQ_POP_FRONT, '0));
    // push front into empty must set the back too, then pop the only entry
    send_beat(make_req(REQ_PUSH_FRONT, VAL_MAX));
    send_beat(make_req(REQ_POP_FRONT, '1));
    // fill to full from both ends with extreme values in the middle
    send_beat(make_req(REQ_PUSH_BACK, VAL_MIN));
    send_beat(make_req(REQ_PUSH_FRONT, VAL_MAX));
    send_beat(make_req(REQ_PUSH_BACK, '0));
    send_beat(make_req(REQ_PUSH_FRONT, '1));
    for (k = 0; k < 10; k++) begin
      send_beat(make_req(k[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom));
    end
    send_beat(make_req(REQ_PUSH_FRONT, 32'sh5A5A_A5A5));
    send_beat(make_req(REQ_PUSH_BACK, 32'sh1234_5678));
    // full: both kinds of push are flagged and dropped
    send_beat(make_req(REQ_PUSH_BACK, 32'sh0F0F_0F0F));
    send_beat(make_req(REQ_PUSH_FRONT, 32'shF0F0_F0F0));
    // searches at first position, last position, and a miss
    send_beat(make_req(REQ_SEARCH, 32'sh5A5A_A5A5));
    send_beat(make_req(REQ_SEARCH, 32'sh1234_5678));
    send_beat(make_req(REQ_SEARCH, 32'sh7654_3210));

    // --- random traffic in stretches of one mix each ---
    mix_left = 0;
    mix      = MIX_BALANCED;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (mix_left == 0) begin
        mix      = traffic_mix_t'($urandom_range(0, 3));
        mix_left = $urandom_range(10, 60);
      end
      mix_left--;
      send_beat(random_request(mix));
    end
    req_valid <= 1'b0;

    // wait out every awaited result, then a quiet window for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
